>>> rtl/core/perm_enum_pkg.sv
// Shared types for the permutation enumerator: control word, opcodes, status flags.
package perm_enum_pkg;

    localparam int STEP_W = 5;
    localparam int ARR_W = 24;
    localparam int PACK_POS = 8;
    localparam int PACK_DIGIT_W = 3;
    localparam logic [3:0] DIGIT_COUNT_RESET = 4'd8;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_FINDJ_INIT,
        OP_FINDJ,
        OP_SWAP,
        OP_REV_INIT,
        OP_READP,
        OP_REV,
        OP_EMIT,
        OP_SETFIN,
        OP_IDENT
    } op_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_NONE,
        COND_NO_REQ,
        COND_RESTART,
        COND_FINISHED,
        COND_P_ZERO,
        COND_NOT_FLAG,
        COND_P_GE_Q,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  ret;
    } ctrl_t;

    typedef struct packed {
        logic req;
        logic restart;
        logic finished;
        logic p_zero;
        logic flag;
        logic p_ge_q;
        logic out_busy;
    } status_t;

endpackage

>>> rtl/core/perm_enum_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module perm_enum_seq
    import perm_enum_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl
);

    localparam step_t ST_ACCEPT   = 5'd0;
    localparam step_t ST_SCAN     = 5'd4;
    localparam step_t ST_FINDJ    = 5'd7;
    localparam step_t ST_REV_TEST = 5'd11;
    localparam step_t ST_EMIT     = 5'd14;
    localparam step_t ST_SETFIN   = 5'd15;
    localparam step_t ST_IDENT    = 5'd16;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        c = '{op: OP_NOP, cond: COND_ALWAYS, target: ST_ACCEPT, ret: 1'b0};
        unique case (s)
            5'd0:  c = '{op: OP_ACCEPT,     cond: COND_NO_REQ,   target: ST_ACCEPT,   ret: 1'b0};
            5'd1:  c = '{op: OP_NOP,        cond: COND_RESTART,  target: ST_IDENT,    ret: 1'b0};
            5'd2:  c = '{op: OP_NOP,        cond: COND_FINISHED, target: ST_EMIT,     ret: 1'b0};
            5'd3:  c = '{op: OP_SCAN_INIT,  cond: COND_NONE,     target: ST_ACCEPT,   ret: 1'b0};
            5'd4:  c = '{op: OP_SCAN,       cond: COND_P_ZERO,   target: ST_SETFIN,   ret: 1'b0};
            5'd5:  c = '{op: OP_NOP,        cond: COND_NOT_FLAG, target: ST_SCAN,     ret: 1'b0};
            5'd6:  c = '{op: OP_FINDJ_INIT, cond: COND_NONE,     target: ST_ACCEPT,   ret: 1'b0};
            5'd7:  c = '{op: OP_FINDJ,      cond: COND_NONE,     target: ST_ACCEPT,   ret: 1'b0};
            5'd8:  c = '{op: OP_NOP,        cond: COND_NOT_FLAG, target: ST_FINDJ,    ret: 1'b0};
            5'd9:  c = '{op: OP_SWAP,       cond: COND_NONE,     target: ST_ACCEPT,   ret: 1'b0};
            5'd10: c = '{op: OP_REV_INIT,   cond: COND_NONE,     target: ST_ACCEPT,   ret: 1'b0};
            5'd11: c = '{op: OP_NOP,        cond: COND_P_GE_Q,   target: ST_EMIT,     ret: 1'b0};
            5'd12: c = '{op: OP_READP,      cond: COND_NONE,     target: ST_ACCEPT,   ret: 1'b0};
            5'd13: c = '{op: OP_REV,        cond: COND_ALWAYS,   target: ST_REV_TEST, ret: 1'b0};
            5'd14: c = '{op: OP_EMIT,       cond: COND_OUT_BUSY, target: ST_EMIT,     ret: 1'b1};
            5'd15: c = '{op: OP_SETFIN,     cond: COND_ALWAYS,   target: ST_EMIT,     ret: 1'b0};
            5'd16: c = '{op: OP_IDENT,      cond: COND_ALWAYS,   target: ST_EMIT,     ret: 1'b0};
            default: c = '{op: OP_NOP,      cond: COND_ALWAYS,   target: ST_ACCEPT,   ret: 1'b0};
        endcase
        return c;
    endfunction

    step_t step_reg;
    step_t step_next;
    logic  take;

    assign ctrl = ucode(step_reg);

    always_comb begin
        unique case (ctrl.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_NONE:     take = 1'b0;
            COND_NO_REQ:   take = !status.req;
            COND_RESTART:  take = status.restart;
            COND_FINISHED: take = status.finished;
            COND_P_ZERO:   take = status.p_zero;
            COND_NOT_FLAG: take = !status.flag;
            COND_P_GE_Q:   take = status.p_ge_q;
            COND_OUT_BUSY: take = status.out_busy;
            default:       take = 1'b0;
        endcase
    end

    always_comb begin
        if (take) begin
            step_next = ctrl.target;
        end else if (ctrl.ret) begin
            step_next = ST_ACCEPT;
        end else begin
            step_next = step_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_ACCEPT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

>>> rtl/core/permutation_enumerator.sv
// Lexicographic permutation enumerator: top level with datapath and output register.
//
// Each transaction on s_ produces one transaction on m_. With s_restart high the
// identity arrangement is loaded and then emitted through the output register.
// With s_restart low the next arrangement in lexicographic order is formed by a
// microcoded sequencer over a single digit read port: it scans from the right for the
// pivot, scans for its successor, swaps the two and reverses the suffix, then emits
// the result. An advance from the descending arrangement scans every position, sets
// the done flag and emits; an advance once done emits the held arrangement again.
// The next request is taken in the cycle after a result is loaded; a result held by a low
// m_ready holds the sequencer until the output register frees. After the descending
// arrangement, the result repeats it with m_done_res set until a restart or a digit
// count write. A write on cfg_ sets the digit count (0 acts as 1, above MAX_DIGITS acts
// as MAX_DIGITS) and reloads the identity.
// One input transaction is worked on at a time; a finished result waits in the output
// register while the next request is accepted.
module permutation_enumerator
    import perm_enum_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_digit_count,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_restart,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ARR_W-1:0]    m_arrangement,
    output logic                m_done_res
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int DW = AW;
    localparam int PACK_N = (MAX_DIGITS < PACK_POS) ? MAX_DIGITS : PACK_POS;

    ctrl_t   ctrl;
    status_t status;

    logic [DW-1:0] digits_reg  [MAX_DIGITS];
    logic [DW-1:0] digits_next [MAX_DIGITS];
    logic [3:0]    digit_count_reg, digit_count_next;
    logic          finished_reg, finished_next;
    logic          restart_reg, restart_next;
    logic [AW-1:0] p_reg, p_next;
    logic [AW-1:0] q_reg, q_next;
    logic [DW-1:0] v_reg, v_next;
    logic [DW-1:0] w_reg, w_next;
    logic          flag_reg, flag_next;
    logic          m_valid_reg, m_valid_next;
    logic [ARR_W-1:0] arr_reg, arr_next;
    logic          done_reg, done_next;

    logic [AW-1:0] last_idx;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          wa_en, wb_en;
    logic [AW-1:0] wa_addr, wb_addr;
    logic [DW-1:0] wa_data, wb_data;
    logic          cfg_acc;
    logic          out_busy;
    logic          out_load;
    logic [ARR_W-1:0] packed_arr;

    perm_enum_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign cfg_ready     = 1'b1;
    assign cfg_acc       = cfg_valid && cfg_ready;
    assign s_ready       = (ctrl.op == OP_ACCEPT);
    assign m_valid       = m_valid_reg;
    assign m_arrangement = arr_reg;
    assign m_done_res    = done_reg;
    assign out_busy      = m_valid_reg && !m_ready;
    assign out_load      = (ctrl.op == OP_EMIT) && !out_busy;

    always_comb begin
        status.req      = s_valid;
        status.restart  = restart_reg;
        status.finished = finished_reg;
        status.p_zero   = (p_reg == '0);
        status.flag     = flag_reg;
        status.p_ge_q   = (p_reg >= q_reg);
        status.out_busy = out_busy;
    end

    // Effective last position from the digit count, clamped to 0..MAX_DIGITS-1.
    always_comb begin
        if (digit_count_reg == 4'd0) begin
            last_idx = '0;
        end else if (32'(digit_count_reg) > MAX_DIGITS) begin
            last_idx = AW'(MAX_DIGITS - 1);
        end else begin
            last_idx = AW'(digit_count_reg - 4'd1);
        end
    end

    // Single read port into the digit registers.
    always_comb begin
        case (ctrl.op)
            OP_SCAN_INIT: rd_addr = last_idx;
            OP_SCAN:      rd_addr = p_reg - AW'(1);
            OP_READP:     rd_addr = p_reg;
            default:      rd_addr = q_reg;
        endcase
        rd_data = (32'(rd_addr) < MAX_DIGITS) ? digits_reg[rd_addr] : '0;
    end

    always_comb begin
        packed_arr = '0;
        for (int i = 0; i < PACK_N; i++) begin
            if (AW'(i) <= last_idx) begin
                packed_arr[i*PACK_DIGIT_W +: PACK_DIGIT_W] = PACK_DIGIT_W'(digits_reg[i]);
            end
        end
    end

    always_comb begin
        digit_count_next = digit_count_reg;
        finished_next    = finished_reg;
        restart_next     = restart_reg;
        p_next           = p_reg;
        q_next           = q_reg;
        v_next           = v_reg;
        w_next           = w_reg;
        flag_next        = flag_reg;
        m_valid_next     = m_valid_reg;
        arr_next         = arr_reg;
        done_next        = done_reg;
        wa_en            = 1'b0;
        wb_en            = 1'b0;
        wa_addr          = p_reg;
        wb_addr          = q_reg;
        wa_data          = w_reg;
        wb_data          = v_reg;

        unique case (ctrl.op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    restart_next = s_restart;
                end
            end
            OP_SCAN_INIT: begin
                p_next = last_idx;
                v_next = rd_data;
            end
            OP_SCAN: begin
                p_next    = p_reg - AW'(1);
                v_next    = rd_data;
                flag_next = (rd_data < v_reg);
            end
            OP_FINDJ_INIT: begin
                q_next = last_idx;
            end
            OP_FINDJ: begin
                w_next    = rd_data;
                flag_next = (rd_data > v_reg);
                // advance the successor pointer only on a miss
                if (rd_data <= v_reg) begin
                    q_next = q_reg - AW'(1);
                end
            end
            OP_SWAP: begin
                wa_en = 1'b1;
                wb_en = 1'b1;
            end
            OP_REV_INIT: begin
                p_next = p_reg + AW'(1);
                q_next = last_idx;
            end
            OP_READP: begin
                w_next = rd_data;
            end
            OP_REV: begin
                wa_en   = 1'b1;
                wa_data = rd_data;
                wb_en   = 1'b1;
                wb_data = w_reg;
                p_next  = p_reg + AW'(1);
                q_next  = q_reg - AW'(1);
            end
            OP_SETFIN: begin
                finished_next = 1'b1;
            end
            OP_IDENT: begin
                finished_next = 1'b0;
            end
            OP_EMIT, OP_NOP: begin
            end
            default: begin
            end
        endcase

        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (cfg_acc || ctrl.op == OP_IDENT) begin
                digits_next[i] = DW'(i);
            end else if (wb_en && wb_addr == AW'(i)) begin
                digits_next[i] = wb_data;
            end else if (wa_en && wa_addr == AW'(i)) begin
                digits_next[i] = wa_data;
            end else begin
                digits_next[i] = digits_reg[i];
            end
        end

        if (cfg_acc) begin
            digit_count_next = cfg_digit_count;
            finished_next    = 1'b0;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
            arr_next     = packed_arr;
            done_next    = finished_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                digits_reg[i] <= DW'(i);
            end
            digit_count_reg <= DIGIT_COUNT_RESET;
            finished_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            digits_reg      <= digits_next;
            digit_count_reg <= digit_count_next;
            finished_reg    <= finished_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        restart_reg <= restart_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        v_reg       <= v_next;
        w_reg       <= w_next;
        flag_reg    <= flag_next;
        arr_reg     <= arr_next;
        done_reg    <= done_next;
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer stayed ready after accepting a request");

    a_finished_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(finished_reg) |-> ($past(ctrl.op == OP_IDENT) || $past(cfg_acc) || $past(!aresetn)))
        else $error("done flag cleared without restart or digit count write");

    a_rev_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_REV) |-> (p_reg < q_reg && q_reg <= last_idx))
        else $error("suffix reversal pointers out of range");

endmodule

>>> tb/permutation_enumerator_test.sv
// Self-checking testbench for the lexicographic permutation enumerator.
`timescale 1ns / 1ps

module permutation_enumerator_test
    import perm_enum_pkg::*;
();

    localparam int MAX_DIGITS = 8;
    localparam time HALF_PERIOD = 5ns;
    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PRINT_CAP = 100;

    localparam logic REQ_ADVANCE = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef enum logic {
        ROW_REQUEST,
        ROW_WRITE
    } row_kind_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [ARR_W-1:0] arrangement;
        logic             done;
    } perm_result_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             restart;
        logic [3:0]       count;
        logic             typed;
        logic [ARR_W-1:0] arrangement;
        logic             done;
    } directed_row_t;

    typedef struct packed {
        logic [3:0] count;
        int         items;
        int         restart_one_in;
        idle_mode_t mode;
    } phase_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [3:0]       cfg_digit_count = 4'd0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_restart = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [ARR_W-1:0] m_arrangement;
    logic             m_done_res;

    // shadow state of the enumerator
    logic [2:0]   shadow_digits [MAX_DIGITS];
    logic         shadow_finished;
    logic [3:0]   shadow_count;

    perm_result_t pending_results [$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    int           sender_idle_pct = 0;
    int           recv_stall_pct = 0;

    directed_row_t directed_rows [27] = '{
        '{ROW_REQUEST, REQ_RESTART, 4'd0, 1'b1, 24'hFAC688, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_WRITE,   REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b1, 24'h0, 1'b1},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b1, 24'h0, 1'b1},
        '{ROW_REQUEST, REQ_RESTART, 4'd0, 1'b1, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b1, 24'h0, 1'b1},
        '{ROW_WRITE,   REQ_ADVANCE, 4'd2, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b1, 24'h1, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b1, 24'h1, 1'b1},
        '{ROW_REQUEST, REQ_RESTART, 4'd0, 1'b1, 24'h8, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b1, 24'h1, 1'b0},
        '{ROW_WRITE,   REQ_ADVANCE, 4'd15, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_RESTART, 4'd0, 1'b1, 24'hFAC688, 1'b0},
        '{ROW_WRITE,   REQ_ADVANCE, 4'd3, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_RESTART, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_WRITE,   REQ_ADVANCE, 4'd8, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0},
        '{ROW_REQUEST, REQ_ADVANCE, 4'd0, 1'b0, 24'h0, 1'b0}
    };

    // small counts run to the end of the sequence; eight positions never finish
    phase_t phases [9] = '{
        '{4'd3,  60,  10, IDLE_NONE},
        '{4'd1,  30,  4,  IDLE_SENDER},
        '{4'd4,  80,  30, IDLE_RECEIVER},
        '{4'd0,  20,  3,  IDLE_BOTH},
        '{4'd5,  130, 0,  IDLE_NONE},
        '{4'd2,  30,  4,  IDLE_BOTH},
        '{4'd15, 60,  8,  IDLE_SENDER},
        '{4'd9,  40,  8,  IDLE_RECEIVER},
        '{4'd6,  60,  16, IDLE_BOTH}
    };

    permutation_enumerator #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_digit_count(cfg_digit_count),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_restart(s_restart),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_arrangement(m_arrangement),
        .m_done_res(m_done_res)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP) begin
            $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        end
        error_count++;
    endtask

    task automatic load_identity();
        for (int i = 0; i < MAX_DIGITS; i++) begin
            shadow_digits[i] = i[2:0];
        end
        shadow_finished = 1'b0;
    endtask

    function automatic int active_positions();
        int n;
        n = shadow_count;
        if (n < 1) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        return n;
    endfunction

    // step to the next arrangement in lexicographic order; clear moved at the last one
    task automatic next_permutation(input int n, output bit moved);
        int pivot;
        int succ;
        int lo;
        int hi;
        logic [2:0] t;
        pivot = n - 2;
        while (pivot >= 0 && shadow_digits[pivot] >= shadow_digits[pivot + 1]) pivot--;
        if (pivot < 0) begin
            moved = 1'b0;
            return;
        end
        succ = n - 1;
        while (shadow_digits[succ] <= shadow_digits[pivot]) succ--;
        t = shadow_digits[pivot];
        shadow_digits[pivot] = shadow_digits[succ];
        shadow_digits[succ] = t;
        lo = pivot + 1;
        hi = n - 1;
        while (lo < hi) begin
            t = shadow_digits[lo];
            shadow_digits[lo] = shadow_digits[hi];
            shadow_digits[hi] = t;
            lo++;
            hi--;
        end
        moved = 1'b1;
    endtask

    task automatic predict_arrangement(input logic restart, output perm_result_t res);
        int n;
        bit moved;
        n = active_positions();
        if (restart == REQ_RESTART) begin
            load_identity();
        end else if (!shadow_finished) begin
            next_permutation(n, moved);
            if (!moved) shadow_finished = 1'b1;
        end
        res.arrangement = '0;
        for (int i = 0; i < n && i < PACK_POS; i++) begin
            res.arrangement[PACK_DIGIT_W*i +: PACK_DIGIT_W] = shadow_digits[i];
        end
        res.done = shadow_finished;
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 65;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                recv_stall_pct = 65;
            end
            default: begin
                sender_idle_pct = 32;
                recv_stall_pct = 32;
            end
        endcase
    endtask

    // call at a rising edge; returns at the edge where the transaction is taken
    task automatic issue_request(input logic restart, input bit typed,
                                 input perm_result_t typed_res);
        perm_result_t res;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_arrangement(restart, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // hold off until every result is back; nothing to drive when none is pending
    task automatic drain_results();
        if (pending_results.size() != 0) begin
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic write_digit_count(input logic [3:0] count);
        cfg_valid <= 1'b1;
        cfg_digit_count <= count;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        shadow_count = count;
        load_identity();
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        perm_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("transaction with nothing pending", 32'(m_arrangement), 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_arrangement !== want.arrangement) begin
                    report_mismatch("arrangement", 32'(m_arrangement), 32'(want.arrangement));
                end
                if (m_done_res !== want.done) begin
                    report_mismatch("done_res", 32'(m_done_res), 32'(want.done));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        perm_result_t typed_res;
        logic restart;
        shadow_count = DIGIT_COUNT_RESET;
        load_identity();
        set_idle_mode(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                drain_results();
                write_digit_count(directed_rows[r].count);
            end else begin
                typed_res.arrangement = directed_rows[r].arrangement;
                typed_res.done = directed_rows[r].done;
                issue_request(directed_rows[r].restart, directed_rows[r].typed, typed_res);
            end
        end

        typed_res = '0;
        foreach (phases[p]) begin
            drain_results();
            set_idle_mode(phases[p].mode);
            write_digit_count(phases[p].count);
            for (int k = 0; k < phases[p].items; k++) begin
                if (phases[p].restart_one_in == 0) begin
                    restart = REQ_ADVANCE;
                end else begin
                    restart = ($urandom_range(phases[p].restart_one_in - 1) == 0) ?
                              REQ_RESTART : REQ_ADVANCE;
                end
                // hold off now and then until every result is back
                if ($urandom_range(63) == 0) drain_results();
                issue_request(restart, 1'b0, typed_res);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never returned", pending_results.size(), 32'h0);
        end
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/perm_enum_pkg.sv
rtl/core/perm_enum_seq.sv
rtl/core/permutation_enumerator.sv
tb/permutation_enumerator_test.sv
